### sv/qpe_pkg.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder package
// Shared types, character constants and encoding helpers for the encoder.
// ----------------------------------------------------------------------------
package qpe_pkg;

	// Reset value of the line limit and default depth of the operation queue.
	localparam logic [7:0] QPE_LIMIT_RESET = 8'd75;
	localparam int         QPE_FIFO_DEPTH  = 4;

	// Characters with a special role in the encoding.
	localparam logic [7:0] CH_EQ       = 8'h3D;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_SP       = 8'h20;
	localparam logic [7:0] CH_DEL      = 8'h7F;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_A        = 8'h41;

	// Kind of work the back end carries out for one queued operation.
	typedef enum logic [1:0] {
		OP_LIT,
		OP_HEX,
		OP_CRLF
	} op_kind_t;

	// One queued operation: an optional soft break followed by the body.
	typedef struct packed {
		op_kind_t    kind;
		logic        soft_brk;
		logic [7:0]  data;
		logic        run_last;
		logic        msg_end;
	} op_t;

	// Result of classifying one byte against the current line position.
	typedef struct packed {
		logic       special;
		logic       soft_brk;
		logic [7:0] new_pos;
	} enc_t;

	// Upper-case hex digit for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {4'd0, d};
		end else begin
			r = CH_A + {4'd0, d} - 8'd10;
		end
		return r;
	endfunction

	// Classify a byte and decide whether a soft break must come first.
	function automatic enc_t encode(input logic [7:0] b, input logic next_cr,
			input logic [7:0] pos, input logic [7:0] limit);
		enc_t       e;
		logic [8:0] inc;
		logic [8:0] sum;
		e.special  = (b < CH_PRINT_LO) || (b >= CH_DEL) || (b == CH_EQ) ||
			((b == CH_SP) && next_cr);
		inc        = e.special ? 9'd3 : 9'd1;
		sum        = {1'b0, pos} + inc;
		e.soft_brk = sum > {1'b0, limit};
		e.new_pos  = e.soft_brk ? inc[7:0] : sum[7:0];
		return e;
	endfunction

endpackage

### sv/qpe_front.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder front end
// Accepts message bytes, keeps the lookahead byte and the line position, and
// turns each byte into a queued operation for the back end.
// ----------------------------------------------------------------------------
module qpe_front import qpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       push,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       full,
	input  logic       q_full,
	output logic       q_push,
	output op_t        q_op
);

	logic [7:0] limit_q;
	logic [7:0] pos_q;
	logic       held_valid_q;
	logic [7:0] held_q;
	logic       pend_q;
	logic [7:0] pend_byte_q;

	logic       accept;
	logic       crlf;
	enc_t       enc_held;
	enc_t       enc_cur;
	enc_t       enc_pend;

	// A second operation for the final byte blocks new input until it is queued.
	assign full   = pend_q || q_full;
	assign accept = push && !full;
	assign crlf   = held_valid_q && (held_q == CH_CR) && (in_byte == CH_LF);

	assign enc_held = encode(held_q, in_byte == CH_CR, pos_q, limit_q);
	assign enc_cur  = encode(in_byte, 1'b0, pos_q, limit_q);
	assign enc_pend = encode(pend_byte_q, 1'b0, pos_q, limit_q);

	// Build the operation that goes to the queue this cycle.
	always_comb begin
		q_push = 1'b0;
		q_op   = '0;
		if (pend_q) begin
			q_push        = !q_full;
			q_op.kind     = enc_pend.special ? OP_HEX : OP_LIT;
			q_op.soft_brk = enc_pend.soft_brk;
			q_op.data     = pend_byte_q;
			q_op.run_last = 1'b1;
			q_op.msg_end  = 1'b1;
		end else if (accept) begin
			if (crlf) begin
				q_push        = 1'b1;
				q_op.kind     = OP_CRLF;
				q_op.run_last = 1'b1;
				q_op.msg_end  = in_last;
			end else if (held_valid_q) begin
				q_push        = 1'b1;
				q_op.kind     = enc_held.special ? OP_HEX : OP_LIT;
				q_op.soft_brk = enc_held.soft_brk;
				q_op.data     = held_q;
				q_op.run_last = !in_last;
			end else if (in_last) begin
				q_push        = 1'b1;
				q_op.kind     = enc_cur.special ? OP_HEX : OP_LIT;
				q_op.soft_brk = enc_cur.soft_brk;
				q_op.data     = in_byte;
				q_op.run_last = 1'b1;
				q_op.msg_end  = 1'b1;
			end
		end
	end

	// Line limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= QPE_LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Lookahead, line position and pending final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			held_valid_q <= 1'b0;
			pend_q       <= 1'b0;
		end else if (pend_q) begin
			if (!q_full) begin
				pend_q <= 1'b0;
				pos_q  <= '0;
			end
		end else if (accept) begin
			if (crlf) begin
				held_valid_q <= 1'b0;
				pos_q        <= '0;
			end else if (held_valid_q) begin
				pos_q        <= enc_held.new_pos;
				held_valid_q <= !in_last;
				pend_q       <= in_last;
			end else begin
				held_valid_q <= !in_last;
				if (in_last) begin
					pos_q <= '0;
				end
			end
		end
	end

	// Byte payload registers.
	always_ff @(posedge clk) begin
		if (accept && !crlf) begin
			held_q      <= in_byte;
			pend_byte_q <= in_byte;
		end
	end

endmodule

### sv/qpe_fifo.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder operation queue
// A short queue of operations between the front end and the back end.
// ----------------------------------------------------------------------------
module qpe_fifo import qpe_pkg::*; #(
	parameter int DEPTH = QPE_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  head_op,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          push_ok;
	logic          pop_ok;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign head_op = mem_q[rd_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/qpe_back.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder back end
// Expands each queued operation into output characters, one per cycle while
// operations are queued and the receiver takes them, through an output register.
// ----------------------------------------------------------------------------
module qpe_back import qpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  op_t        head_op,
	input  logic       q_empty,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       msg_end
);

	logic [2:0] step_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_run_last_q;
	logic       out_msg_end_q;

	logic [2:0] soft_len;
	logic [2:0] body_len;
	logic [2:0] body_idx;
	logic       last_char;
	logic       load;
	logic [7:0] ch;

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign run_last = out_run_last_q;
	assign msg_end  = out_msg_end_q;

	// The output register takes a new character when it is free or drained.
	assign load  = !q_empty && (!out_valid_q || pop);
	assign q_pop = load && last_char;

	// Character at the current step of the head operation.
	always_comb begin
		soft_len = head_op.soft_brk ? 3'd3 : 3'd0;
		body_idx = step_q - soft_len;
		unique case (head_op.kind)
			OP_LIT:  body_len = 3'd1;
			OP_HEX:  body_len = 3'd3;
			OP_CRLF: body_len = 3'd2;
			default: body_len = 3'd1;
		endcase
		last_char = step_q == (soft_len + body_len - 3'd1);
		if (head_op.soft_brk && (step_q < 3'd3)) begin
			unique case (step_q)
				3'd0:    ch = CH_EQ;
				3'd1:    ch = CH_CR;
				default: ch = CH_LF;
			endcase
		end else begin
			unique case (head_op.kind)
				OP_LIT: ch = head_op.data;
				OP_HEX: begin
					unique case (body_idx)
						3'd0:    ch = CH_EQ;
						3'd1:    ch = hex_char(head_op.data[7:4]);
						default: ch = hex_char(head_op.data[3:0]);
					endcase
				end
				OP_CRLF: ch = (body_idx == 3'd0) ? CH_CR : CH_LF;
				default: ch = head_op.data;
			endcase
		end
	end

	// Step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			step_q      <= last_char ? 3'd0 : step_q + 3'd1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q     <= ch;
			out_run_last_q <= last_char && head_op.run_last;
			out_msg_end_q  <= last_char && head_op.msg_end;
		end
	end

endmodule

### sv/quoted_printable_encoder_top.sv
// Path: the characters caused by an item pass through the operation queue and
// the output register before they reach the result ports.
// Throughput: one output character per cycle while the receiver takes them; an
// item yields 0 to 12 characters, typically 1 to 3, and the front end takes one
// item per cycle while the queue has room and no second operation is pending.
// Reset: asynchronous, clears the lookahead, line position, queue and output.
// ----------------------------------------------------------------------------
// Quoted-printable encoder top level
// Front end classifies bytes, a short queue decouples it from the back end
// that emits the encoded characters.
// ----------------------------------------------------------------------------
module quoted_printable_encoder_top import qpe_pkg::*; #(
	parameter int FIFO_DEPTH = QPE_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       msg_end
);

	logic q_push;
	op_t  q_op;
	logic q_full;
	logic q_pop;
	op_t  head_op;
	logic q_empty;

	// Byte classification and line tracking.
	qpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.full      (full),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (q_op)
	);

	// Operation queue.
	qpe_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_op),
		.full    (q_full),
		.pop     (q_pop),
		.head_op (head_op),
		.empty   (q_empty)
	);

	// Character generation.
	qpe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_op  (head_op),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.run_last (run_last),
		.msg_end  (msg_end)
	);

endmodule

### test/tb_quoted_printable_encoder_top.sv
// ----------------------------------------------------------------------------
// Quoted-printable encoder testbench
// Sends messages through the encoder under random idling on both sides and
// checks every encoded character against a cycle-free model of the encoding
// rules. Directed messages cover the escape cases and hard and soft breaks.
// Random messages run before and after them at several line limits. One long
// receiver stall fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_quoted_printable_encoder_top;
	import qpe_pkg::*;

	// One raw message byte waiting to be sent.
	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} qp_item_t;

	// One encoded character with its markers.
	typedef struct packed {
		logic [7:0] ch;
		logic       run_last;
		logic       msg_end;
	} qp_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] in_byte = 8'd0;
	logic       in_last = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       msg_end;

	quoted_printable_encoder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.msg_end   (msg_end)
	);

	// Clock with a period of 4.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	qp_item_t   tx_items[$];
	qp_char_t   exp_chars[$];
	logic [7:0] step_chars[$];

	// Encoder state as the model tracks it.
	logic [7:0] mdl_held = 8'd0;
	bit         mdl_held_v = 1'b0;
	int         mdl_pos = 0;
	int         mdl_limit = 75;
	string      hex_digits = "0123456789ABCDEF";

	int         err_count = 0;
	int         burst_left[2];
	int         tx_accepted = 0;
	logic       rx_hold = 1'b0;

	// Input driver state.
	qp_item_t   tx_cur = '0;
	bit         tx_busy = 1'b0;
	int         tx_wait = 0;

	// Print one mismatch line and count it.
	task automatic flag_error(input string what);
		err_count++;
		$display("ERROR @%0t: %s", $time, what);
	endtask

	// Wait before the next transfer on one side; sometimes a run of zero waits.
	function automatic int draw_wait(input int side);
		int w;
		if (burst_left[side] > 0) begin
			burst_left[side]--;
			w = 0;
		end else begin
			w = $urandom_range(0, 13);
			if ($urandom_range(0, 11) == 0)
				burst_left[side] = $urandom_range(8, 40);
		end
		return w;
	endfunction

	// Encode one byte as a literal or a hex triplet, with a soft break first
	// when it would overrun the line.
	task automatic encode_one(input logic [7:0] b, input bit next_cr);
		bit esc;
		int width;
		esc = (b < CH_PRINT_LO) || (b >= CH_DEL) || (b == CH_EQ) ||
			((b == CH_SP) && next_cr);
		width = esc ? 3 : 1;
		if (mdl_pos + width > mdl_limit) begin
			step_chars.push_back(CH_EQ);
			step_chars.push_back(CH_CR);
			step_chars.push_back(CH_LF);
			mdl_pos = width;
		end else begin
			mdl_pos = mdl_pos + width;
		end
		if (esc) begin
			step_chars.push_back(CH_EQ);
			step_chars.push_back(hex_digits[b[7:4]]);
			step_chars.push_back(hex_digits[b[3:0]]);
		end else begin
			step_chars.push_back(b);
		end
	endtask

	// Work out the characters that one accepted byte releases.
	task automatic qp_predict(input logic [7:0] b, input logic last);
		bit       taken;
		int       k;
		qp_char_t c;
		step_chars.delete();
		taken = 1'b0;
		if (mdl_held_v) begin
			if (mdl_held == CH_CR && b == CH_LF) begin
				// Hard line break passes through.
				step_chars.push_back(CH_CR);
				step_chars.push_back(CH_LF);
				mdl_pos = 0;
				mdl_held_v = 1'b0;
				taken = 1'b1;
			end else begin
				encode_one(mdl_held, b == CH_CR);
			end
		end
		if (!taken) begin
			mdl_held = b;
			mdl_held_v = 1'b1;
			if (last) begin
				encode_one(b, 1'b0);
				mdl_held_v = 1'b0;
			end
		end
		if (last) begin
			mdl_held_v = 1'b0;
			mdl_held = 8'd0;
			mdl_pos = 0;
		end
		for (k = 0; k < step_chars.size(); k++) begin
			c.ch = step_chars[k];
			c.run_last = (k == step_chars.size() - 1);
			c.msg_end = last && (k == step_chars.size() - 1);
			exp_chars.push_back(c);
		end
	endtask

	task automatic queue_item(input logic [7:0] b, input logic last);
		qp_item_t it;
		it.b = b;
		it.last = last;
		tx_items.push_back(it);
	endtask

	// Byte mix weighted toward the characters with special handling.
	function automatic logic [7:0] pick_byte();
		int         r;
		logic [7:0] v;
		r = $urandom_range(0, 99);
		if (r < 40)
			v = 8'($urandom_range(33, 126));
		else if (r < 50)
			v = CH_SP;
		else if (r < 65)
			v = CH_CR;
		else if (r < 72)
			v = CH_LF;
		else if (r < 80)
			v = CH_EQ;
		else
			v = 8'($urandom_range(0, 255));
		return v;
	endfunction

	// Random messages, mostly short; a CR is often followed by LF.
	task automatic add_random_phase(input int n_items);
		int         count;
		int         len;
		int         k;
		logic [7:0] b;
		count = 0;
		while (count < n_items) begin
			len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 60);
			if (count + len > n_items)
				len = n_items - count;
			k = 0;
			while (k < len) begin
				b = pick_byte();
				k++;
				queue_item(b, k == len);
				if (b == CH_CR && k < len && $urandom_range(0, 9) < 6) begin
					k++;
					queue_item(CH_LF, k == len);
				end
			end
			count = count + len;
		end
	endtask

	// Wait until every queued byte is sent and every character has come out.
	task automatic wait_drained();
		while (tx_items.size() != 0 || tx_busy || exp_chars.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		mdl_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Input driver: offers queued bytes with a random wait between transfers.
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			tx_busy = 1'b0;
			tx_wait = 0;
		end else begin
			if (push && !full) begin
				qp_predict(tx_cur.b, tx_cur.last);
				tx_accepted++;
				tx_busy = 1'b0;
				tx_wait = draw_wait(0);
			end
			if (!tx_busy) begin
				if (tx_wait > 0)
					tx_wait--;
				else if (tx_items.size() > 0) begin
					tx_cur = tx_items.pop_front();
					tx_busy = 1'b1;
				end
			end
			push <= tx_busy;
			in_byte <= tx_cur.b;
			in_last <= tx_cur.last;
		end
	end

	// Output monitor: checks each transfer against the oldest expectation.
	qp_char_t rx_exp;
	int       rx_wait = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
			rx_wait = 0;
		end else begin
			if (pop && !empty) begin
				if (exp_chars.size() == 0) begin
					flag_error($sformatf("unexpected char %h run_last %b msg_end %b",
						out_byte, run_last, msg_end));
				end else begin
					rx_exp = exp_chars.pop_front();
					if (out_byte !== rx_exp.ch || run_last !== rx_exp.run_last ||
							msg_end !== rx_exp.msg_end)
						flag_error($sformatf("got %h/%b/%b, expected %h/%b/%b",
							out_byte, run_last, msg_end,
							rx_exp.ch, rx_exp.run_last, rx_exp.msg_end));
				end
				rx_wait = draw_wait(1);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			pop <= (rx_wait == 0) && !rx_hold;
		end
	end

	// One long receiver stall while the sender keeps offering bytes.
	initial begin
		wait (tx_accepted >= 60);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Run limit.
	initial begin
		#2000000;
		$display("** quoted_printable_encoder_top: FAILED **");
		$finish;
	end

	// Phases: reset limit, directed cases, then random at several limits.
	initial begin
		burst_left[0] = 0;
		burst_left[1] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_random_phase(20);
		wait_drained();

		write_limit(8'd4);
		// Single byte that is also the last one.
		queue_item(8'h00, 1'b1);
		// Plain text that overruns the line.
		queue_item("a", 1'b0);
		queue_item("b", 1'b0);
		queue_item("c", 1'b0);
		queue_item("d", 1'b0);
		queue_item("e", 1'b1);
		// Space before CR, hard break, then escapes.
		queue_item(CH_SP, 1'b0);
		queue_item(CH_CR, 1'b0);
		queue_item(CH_LF, 1'b0);
		queue_item(8'hFF, 1'b0);
		queue_item(CH_EQ, 1'b0);
		queue_item(CH_DEL, 1'b1);
		// CR without LF, printable bounds, space not before CR, CR at the end.
		queue_item(CH_CR, 1'b0);
		queue_item("x", 1'b0);
		queue_item(8'h1F, 1'b0);
		queue_item(CH_SP, 1'b0);
		queue_item(8'h7E, 1'b0);
		queue_item(8'h80, 1'b0);
		queue_item(CH_CR, 1'b1);
		// Space as the last byte stays literal.
		queue_item(8'h21, 1'b0);
		queue_item(CH_SP, 1'b1);
		// Two CRs, then a hard break that ends the message.
		queue_item(8'hFE, 1'b0);
		queue_item(CH_CR, 1'b0);
		queue_item(CH_CR, 1'b0);
		queue_item(CH_LF, 1'b1);
		wait_drained();

		write_limit(8'd255);
		add_random_phase(25);
		wait_drained();

		write_limit(8'($urandom_range(4, 12)));
		add_random_phase(20);
		wait_drained();

		write_limit(8'($urandom_range(4, 255)));
		add_random_phase(15);
		wait_drained();

		write_limit(8'd4);
		add_random_phase(15);
		wait_drained();

		if (err_count == 0)
			$display("** quoted_printable_encoder_top: PASSED **");
		else
			$display("** quoted_printable_encoder_top: FAILED **");
		$finish;
	end

endmodule
